### hw/rtl/sddf_pkg.sv
// Shared types and constants for the signed decimal digit formatter.
package sddf_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int VAL_W      = 32;
  localparam int ADDR_W     = 4;
  localparam int CODE_W     = 8;
  localparam int QUOT_W     = 29;  // floor((2^32 - 1) / 10) fits in 29 bits
  localparam int PROD_W     = 64;

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NUM_DIGITS);
  localparam logic [ADDR_W-1:0] POINT_POS  = 4'd3;
  localparam logic [CODE_W-1:0] CODE_MINUS = 8'd10;
  localparam logic [CODE_W-1:0] CODE_BLANK = 8'd15;

  localparam logic [VAL_W-1:0] POS_LIMIT = 32'd99999999;
  localparam logic [VAL_W-1:0] NEG_LIMIT = 32'd9999999;

  // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
  localparam logic [VAL_W-1:0] RECIP10 = 32'hCCCCCCCD;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_MUL,
    S_REM,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] code;
    logic              last;
    logic              ovf;
  } wr_word_t;

endpackage

### hw/rtl/signed_decimal_digit_formatter_top.sv
// Top level of the signed decimal digit formatter: ports, sequencer, output register.
//
//  channel | dir | tdata (low bit up)                      | tuser        | tlast
//  --------+-----+-----------------------------------------+--------------+--------
//  in_     | in  | value[31:0], digit_count[35:32], pad    | dec_point    | -
//  out_    | out | digit_address[3:0], segment_code[11:4]  | overflow     | is_last
//
// Writes: one input word yields 8 writes (9 for a negative value with zero
//   count). Each digit position steps through pick, multiply, remainder and
//   emit on the shared divide-by-ten unit; a minus or blank position steps
//   through pick and emit only. The next word is accepted only once the
//   sequencer has returned to idle after its last write.
// Reset: rst_n synchronous, active low; clears sequencer state and out_tvalid.
// Stalls: out_tready low holds the output register; the sequencer waits in its
//   emit step. in_tready is high only while the sequencer is idle, even if the
//   final write still sits in the output register.
module signed_decimal_digit_formatter_top
  import sddf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], digit_count[35:32], zero pad
  input  logic [0:0]  in_tuser,   // dec_point

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // digit_address[3:0], segment_code[11:4], zero pad
  output logic [0:0]  out_tuser,  // overflow
  output logic        out_tlast   // is_last
);

  logic     wr_valid;
  logic     wr_ready;
  wr_word_t wr;

  logic     out_valid_r;
  wr_word_t out_word_r;

  sddf_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .value       (in_tdata[31:0]),
    .digit_count (in_tdata[35:32]),
    .dec_point   (in_tuser[0]),
    .wr_valid    (wr_valid),
    .wr_ready    (wr_ready),
    .wr          (wr)
  );

  // output register: loads when empty or being drained this cycle
  assign wr_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_ready) begin
      out_valid_r <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      out_word_r <= wr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_word_r.code, out_word_r.addr};
  assign out_tuser  = out_word_r.ovf;
  assign out_tlast  = out_word_r.last;

endmodule

### hw/rtl/sddf_div10.sv
// Shared divide-by-ten unit: registered reciprocal product, then quotient and digit.
module sddf_div10
  import sddf_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [VAL_W-1:0]  dividend,
  output logic [QUOT_W-1:0] quotient,
  output logic [3:0]        remainder
);

  logic [PROD_W-1:0] prod_r;
  logic [3:0]        q_x8;
  logic [3:0]        q_x2;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(dividend) * PROD_W'(RECIP10);
    end
  end

  // dividend is held stable between load and use
  assign quotient = prod_r[PROD_W-1 -: QUOT_W];

  // remainder < 10, so low four bits of dividend - 10*q are enough
  assign q_x8      = {quotient[0], 3'b000};
  assign q_x2      = {quotient[2:0], 1'b0};
  assign remainder = dividend[3:0] - q_x8 - q_x2;

endmodule

### hw/rtl/sddf_seq.sv
// Sequencer: walks display positions, drives the divide unit, builds writes.
module sddf_seq
  import sddf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  value,
  input  logic [3:0]        digit_count,
  input  logic              dec_point,
  output logic              wr_valid,
  input  logic              wr_ready,
  output wr_word_t          wr
);

  seq_state_t state_r, state_nxt;

  logic [VAL_W-1:0]  rest_r, rest_nxt;
  logic [ADDR_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              dp_r, dp_nxt;
  logic              neg_r, neg_nxt;
  logic              ovf_r, ovf_nxt;

  logic              div_load;
  logic [QUOT_W-1:0] div_quot;
  logic [3:0]        div_rem;

  logic              in_neg;
  logic [VAL_W-1:0]  in_mag;
  logic [ADDR_W-1:0] in_n;
  logic              is_last;
  logic              want_digit;

  sddf_div10 u_div (
    .clk       (clk),
    .load      (div_load),
    .dividend  (rest_r),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_neg = value[VAL_W-1];
  assign in_mag = in_neg ? (~value + 32'd1) : value;
  assign in_n   = (digit_count > LAST_ADDR) ? LAST_ADDR : digit_count;

  assign is_last    = (addr_r == LAST_ADDR);
  assign want_digit = (addr_r <= n_r) && !(neg_r && (addr_r == n_r));

  assign in_ready = (state_r == S_IDLE);
  assign wr_valid = (state_r == S_OUT);
  assign wr.addr  = addr_r;
  assign wr.code  = code_r;
  assign wr.last  = is_last;
  assign wr.ovf   = is_last && ovf_r;

  always_comb begin
    state_nxt = state_r;
    rest_nxt  = rest_r;
    n_nxt     = n_r;
    addr_nxt  = addr_r;
    code_nxt  = code_r;
    dp_nxt    = dp_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    div_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rest_nxt  = in_mag;
          n_nxt     = in_n;
          dp_nxt    = dec_point;
          neg_nxt   = in_neg;
          ovf_nxt   = in_neg ? (in_mag > NEG_LIMIT) : (in_mag > POS_LIMIT);
          // negative with zero count: minus goes to address 0
          addr_nxt  = (in_neg && (in_n == '0)) ? '0 : ADDR_W'(1);
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (want_digit) begin
          state_nxt = S_MUL;
        end else begin
          code_nxt  = (neg_r && (addr_r == n_r)) ? CODE_MINUS : CODE_BLANK;
          state_nxt = S_OUT;
        end
      end
      S_MUL: begin
        div_load  = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        rest_nxt  = VAL_W'(div_quot);
        code_nxt  = {dp_r && (addr_r == POINT_POS), 3'b000, div_rem};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (wr_ready) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r + ADDR_W'(1);
            state_nxt = S_PICK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    n_r    <= n_nxt;
    addr_r <= addr_nxt;
    code_r <= code_nxt;
    dp_r   <= dp_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
  end

endmodule

### hw/rtl/sddf_checker.sv
// Port-level checks for the signed decimal digit formatter, bound to the top level.
module sddf_checker
  import sddf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous word still in progress");

  // overflow only rides on the final write
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("overflow flag on a non-final write");

  // the final write always targets the top display position
  a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == LAST_ADDR)
    else $error("final write not at the top position");

  // address zero carries only the minus sign
  a_addr0_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == 4'd0) |-> out_tdata[11:4] == CODE_MINUS)
    else $error("address zero written with something other than minus");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word dropped or changed");

endmodule

bind signed_decimal_digit_formatter_top sddf_checker u_sddf_checker (.*);
